// File: hdl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants for the bitmap stream parser
// Result record, result kinds, error codes and header byte positions.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam logic [7:0]  SIG_B        = 8'h42;
	localparam logic [7:0]  SIG_M        = 8'h4D;
	localparam logic [15:0] PLANES_OK    = 16'd1;
	localparam logic [15:0] BPP_OK       = 16'd24;
	localparam logic [31:0] HEADER_BYTES = 32'd30;

	// byte positions of interest within the header
	localparam logic [31:0] POS_SIG0     = 32'd0;
	localparam logic [31:0] POS_SIG1     = 32'd1;
	localparam logic [31:0] POS_SIZE     = 32'd5;
	localparam logic [31:0] POS_OFFSET   = 32'd13;
	localparam logic [31:0] POS_WIDTH    = 32'd21;
	localparam logic [31:0] POS_HEIGHT   = 32'd25;
	localparam logic [31:0] POS_PLANES   = 32'd27;
	localparam logic [31:0] POS_BPP      = 32'd29;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_SIGNATURE = 3'd0,
		ERR_PLANES    = 3'd1,
		ERR_BPP       = 3'd2,
		ERR_OFFSET    = 3'd3,
		ERR_DIM       = 3'd4
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] row;
		logic [11:0] col;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [31:0] file_size;
		logic [31:0] data_offset;
		err_t        error_code;
		logic        last;
	} res_t;

	// control from the header parser to the pixel assembler
	typedef struct packed {
		logic init;      // header accepted, load pixel counters
		logic pix_byte;  // current beat is a pixel component
	} pix_ctl_t;

endpackage

// File: hdl/bsp_pix.sv
// ----------------------------------------------------------------------------
// bsp_pix: pixel assembler
// Gathers blue, green, red bytes into pixels and tracks row and column.
// ----------------------------------------------------------------------------
module bsp_pix import bsp_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pix_ctl_t                          pctl,
	input  logic [7:0]                        data_byte,
	input  logic [$clog2(MAX_DIM + 2) - 1:0]  width,
	input  logic [$clog2(MAX_DIM + 2) - 1:0]  height,
	output logic                              pix_done,
	output logic                              res_valid,
	output res_t                              res
);

	localparam int DW = $clog2(MAX_DIM + 2);

	typedef enum logic [2:0] {
		COMP_BLUE  = 3'b001,
		COMP_GREEN = 3'b010,
		COMP_RED   = 3'b100
	} comp_t;

	comp_t         comp_q;
	logic [7:0]    blue_q;
	logic [7:0]    green_q;
	logic [DW-1:0] row_q;
	logic [DW-1:0] col_q;

	logic          col_wrap;
	logic          row_zero;
	logic [31:0]   row32;
	logic [31:0]   col32;

	assign col_wrap = ({1'b0, col_q} + (DW + 1)'(1)) >= {1'b0, width};
	assign row_zero = (row_q == '0);
	assign row32    = 32'(row_q);
	assign col32    = 32'(col_q);

	// a red byte here would close the image; depends on registers only
	assign pix_done = (comp_q == COMP_RED) && col_wrap && row_zero;

	always_comb begin
		res       = '0;
		res.kind  = KIND_PIXEL;
		res.red   = data_byte;
		res.green = green_q;
		res.blue  = blue_q;
		res.row   = row32[11:0];
		res.col   = col32[11:0];
		res.last  = col_wrap && row_zero;
		res_valid = pctl.pix_byte && (comp_q == COMP_RED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= COMP_BLUE;
			row_q  <= '0;
			col_q  <= '0;
		end else if (pctl.init) begin
			comp_q <= COMP_BLUE;
			row_q  <= height - DW'(1);
			col_q  <= '0;
		end else if (pctl.pix_byte) begin
			unique case (comp_q)
				COMP_BLUE:  comp_q <= COMP_GREEN;
				COMP_GREEN: comp_q <= COMP_RED;
				default: begin
					comp_q <= COMP_BLUE;
					if (col_wrap) begin
						col_q <= '0;
						if (!row_zero) begin
							row_q <= row_q - DW'(1);
						end
					end else begin
						col_q <= col_q + DW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pctl.pix_byte && comp_q == COMP_BLUE) begin
			blue_q <= data_byte;
		end
		if (pctl.pix_byte && comp_q == COMP_GREEN) begin
			green_q <= data_byte;
		end
	end

endmodule

// File: hdl/bsp_ctl.sv
// ----------------------------------------------------------------------------
// bsp_ctl: header parser and phase control
// Checks the signature, captures header fields, runs the skip to pixel data.
// ----------------------------------------------------------------------------
module bsp_ctl import bsp_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [7:0]                        data_byte,
	input  logic                              start_of_file,
	input  logic                              pix_done,
	output pix_ctl_t                          pctl,
	output logic [$clog2(MAX_DIM + 2) - 1:0]  width,
	output logic [$clog2(MAX_DIM + 2) - 1:0]  height,
	output logic                              res_valid,
	output res_t                              res
);

	localparam int DW = $clog2(MAX_DIM + 2);
	localparam logic [31:0] MAX32 = 32'(MAX_DIM);
	localparam logic [DW-1:0] DIM_SAT = DW'(MAX_DIM + 1);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_SKIP = 4'b0100,
		PH_PIX  = 4'b1000
	} phase_t;

	phase_t        phase_q, phase_d, phase_e;
	logic [31:0]   pos_q, pos_d, pos_e;
	logic [31:0]   acc_q, acc_n;
	logic [31:0]   size_q;
	logic [31:0]   offset_q;
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [DW-1:0] dim_sat;
	logic [31:0]   w32;
	logic [31:0]   h32;
	logic          in_head;

	// a start marker restarts at byte 0 regardless of the current phase
	assign phase_e = start_of_file ? PH_HEAD : phase_q;
	assign pos_e   = start_of_file ? '0 : pos_q;
	assign acc_n   = {data_byte, acc_q[31:8]};
	assign dim_sat = (acc_n > MAX32) ? DIM_SAT : acc_n[DW-1:0];
	assign in_head = fire && (phase_e == PH_HEAD);
	assign w32     = 32'(width_q);
	assign h32     = 32'(height_q);
	assign width   = width_q;
	assign height  = height_q;

	always_comb begin
		phase_d          = phase_q;
		pos_d            = pos_q;
		pctl             = '0;
		res_valid        = 1'b0;
		res              = '0;
		res.kind         = KIND_ERROR;
		res.error_code   = ERR_SIGNATURE;
		if (fire) begin
			unique case (phase_e)
				PH_HEAD: begin
					phase_d = PH_HEAD;
					pos_d   = pos_e + 32'd1;
					if (pos_e == POS_SIG0 && data_byte != SIG_B) begin
						res_valid = 1'b1;
						phase_d   = PH_IDLE;
					end else if (pos_e == POS_SIG1 && data_byte != SIG_M) begin
						res_valid = 1'b1;
						phase_d   = PH_IDLE;
					end else if (pos_e == POS_PLANES && acc_n[31:16] != PLANES_OK) begin
						res_valid      = 1'b1;
						res.error_code = ERR_PLANES;
						phase_d        = PH_IDLE;
					end else if (pos_e == POS_BPP) begin
						res_valid = 1'b1;
						phase_d   = PH_IDLE;
						if (acc_n[31:16] != BPP_OK) begin
							res.error_code = ERR_BPP;
						end else if (offset_q < HEADER_BYTES) begin
							res.error_code = ERR_OFFSET;
						end else if (w32 > MAX32 || h32 > MAX32) begin
							res.error_code = ERR_DIM;
						end else begin
							res.kind         = KIND_HEADER;
							res.error_code   = ERR_SIGNATURE;
							res.image_width  = w32[12:0];
							res.image_height = h32[12:0];
							res.file_size    = size_q;
							res.data_offset  = offset_q;
							if (width_q != '0 && height_q != '0) begin
								phase_d   = PH_SKIP;
								pctl.init = 1'b1;
							end
						end
					end
				end
				PH_SKIP: begin
					if (pos_q < offset_q) begin
						pos_d = pos_q + 32'd1;
					end else begin
						pctl.pix_byte = 1'b1;
						phase_d       = pix_done ? PH_IDLE : PH_PIX;
					end
				end
				PH_PIX: begin
					pctl.pix_byte = 1'b1;
					if (pix_done) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_head) begin
			acc_q <= acc_n;
			if (pos_e == POS_SIZE) begin
				size_q <= acc_n;
			end
			if (pos_e == POS_OFFSET) begin
				offset_q <= acc_n;
			end
			if (pos_e == POS_WIDTH) begin
				width_q <= dim_sat;
			end
			if (pos_e == POS_HEIGHT) begin
				height_q <= dim_sat;
			end
		end
	end

endmodule

// File: hdl/bmp_stream_header_pixel_parser.sv
// ----------------------------------------------------------------------------
// bmp_stream_header_pixel_parser: 24-bit bitmap header and pixel parser
// Byte-stream front end that validates a bitmap header and emits pixels.
// ----------------------------------------------------------------------------
// Feed a bitmap file one byte per beat, with start_of_file high on byte 0
// (that beat always restarts the parser). Bytes 0..29 are the header: after
// byte 29 one header beat (kind 0) carries width, height, file size and the
// pixel-data offset, or an error beat (kind 2) is sent as soon as a check
// fails: a wrong signature at byte 0 or 1, a plane count other than one at
// byte 27, and at byte 29 bits per pixel other than 24, an offset below 30,
// or a dimension above MAX_DIM. Bytes up to the offset are dropped, then
// each blue, green, red triple yields one pixel beat (kind 1) with the row
// counting down from height-1 and the column counting up; the final pixel
// has last set. Rows are packed with no padding. After an error, after the
// last pixel, and for an empty image, bytes are dropped until the next
// start marker. Throughput is one byte per clock while the output is not
// stalled: a beat is registered at the input, resolved against the parser
// state, and any result lands in the output register. in_stall follows
// out_stall only when the input register is occupied and the output
// register is full and stalled.
// ----------------------------------------------------------------------------
module bmp_stream_header_pixel_parser import bsp_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [11:0] row,
	output logic [11:0] col,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic [31:0] file_size,
	output logic [31:0] data_offset,
	output logic [2:0]  error_code,
	output logic        last
);

	localparam int DW = $clog2(MAX_DIM + 2);

	// input stage
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          sof_s1;

	// output stage
	logic          valid_s2;
	res_t          res_s2;

	logic          adv;
	logic          fire;
	pix_ctl_t      pctl;
	logic [DW-1:0] width;
	logic [DW-1:0] height;
	logic          pix_done;
	logic          hdr_valid;
	res_t          hdr_res;
	logic          pix_valid;
	res_t          pix_res;

	// advance the output register whenever it is empty or being drained
	assign adv      = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

	bsp_ctl #(
		.MAX_DIM(MAX_DIM)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.data_byte    (data_s1),
		.start_of_file(sof_s1),
		.pix_done     (pix_done),
		.pctl         (pctl),
		.width        (width),
		.height       (height),
		.res_valid    (hdr_valid),
		.res          (hdr_res)
	);

	bsp_pix #(
		.MAX_DIM(MAX_DIM)
	) u_pix (
		.clk      (clk),
		.arst_n   (arst_n),
		.pctl     (pctl),
		.data_byte(data_s1),
		.width    (width),
		.height   (height),
		.pix_done (pix_done),
		.res_valid(pix_valid),
		.res      (pix_res)
	);

	// header/error and pixel results never occur on the same beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fire && (hdr_valid || pix_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= pix_valid ? pix_res : hdr_res;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = res_s2.kind;
	assign red          = res_s2.red;
	assign green        = res_s2.green;
	assign blue         = res_s2.blue;
	assign row          = res_s2.row;
	assign col          = res_s2.col;
	assign image_width  = res_s2.image_width;
	assign image_height = res_s2.image_height;
	assign file_size    = res_s2.file_size;
	assign data_offset  = res_s2.data_offset;
	assign error_code   = res_s2.error_code;
	assign last         = res_s2.last;

endmodule
